>>> rtl/bf3_pkg.sv
package bf3_pkg;

	localparam int PIXEL_W     = 8;
	localparam int WIN_SIZE    = 3;
	localparam int COL_SUM_W   = 10;
	localparam int WIN_SUM_W   = 12;

	localparam int CFG_WIDTH_W  = 11;
	localparam int CFG_HEIGHT_W = 13;
	localparam int CFG_DATA_W   = 13;
	localparam int CFG_INDEX_W  = 1;
	localparam int CFG_WIDTH_MAX = (1 << CFG_WIDTH_W) - 1;
	localparam int ROW_W        = 12;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	localparam logic [CFG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd512;
	localparam logic [CFG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 13'd512;
	localparam logic [CFG_HEIGHT_W-1:0] MAX_HEIGHT         = 13'd4096;

	localparam logic OP_PIXEL = 1'b0;
	localparam logic OP_FLUSH = 1'b1;

	// floor(x / 9) == (x * 7282) >> 16 for every window sum (x <= 2295)
	localparam int                     DIV9_RECIP_W = 13;
	localparam logic [DIV9_RECIP_W-1:0] DIV9_RECIP  = 13'd7282;
	localparam int                     DIV9_SHIFT   = 16;
	localparam int                     PROD_W       = WIN_SUM_W + DIV9_RECIP_W;

	localparam int OUT_FIFO_DEPTH = 8;
	localparam int FIFO_PTR_W     = $clog2(OUT_FIFO_DEPTH);
	localparam int FIFO_CNT_W     = $clog2(OUT_FIFO_DEPTH + 1);

	typedef logic [PIXEL_W-1:0] pixel_t;

	// [0] = two rows above, [1] = row above, [2] = current row
	typedef pixel_t [WIN_SIZE-1:0] column_t;

	typedef struct packed {
		logic   operation;
		pixel_t pixel;
	} bf3_in_t;

	typedef struct packed {
		pixel_t filtered_pixel;
		logic   last_of_frame;
	} bf3_out_t;

endpackage

>>> rtl/bf3_stream_if.sv
interface bf3_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

>>> rtl/bf3_ram.sv
module bf3_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	// read returns the contents before a write at the same edge
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a_q <= mem[raddr_a];
		rdata_b_q <= mem[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;
endmodule

>>> rtl/bf3_col_cell.sv
module bf3_col_cell (
	input  logic                      clk,
	input  logic                      shift_en,
	input  bf3_pkg::column_t          col_in,
	output bf3_pkg::column_t          col_out,
	output logic [bf3_pkg::COL_SUM_W-1:0] col_sum
);
	import bf3_pkg::*;

	column_t col_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			col_q <= col_in;
		end
	end

	assign col_out = col_q;
	assign col_sum = COL_SUM_W'(col_q[0]) + COL_SUM_W'(col_q[1]) + COL_SUM_W'(col_q[2]);
endmodule

>>> rtl/bf3_out_fifo.sv
module bf3_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  bf3_pkg::bf3_out_t push_data,
	input  logic              pop,
	output logic              out_valid,
	output bf3_pkg::bf3_out_t out_data
);
	import bf3_pkg::*;

	bf3_out_t              mem_q [OUT_FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FIFO_CNT_W'(1);
				2'b01:   count_q <= count_q - FIFO_CNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign out_valid = (count_q != '0);
	assign out_data  = mem_q[rd_ptr_q];
endmodule

>>> rtl/box_filter_3x3_core.sv
// 3x3 mean filter, raster in / raster out, frame size set by two registers.
// Throughput: one request per clock, pixel or flush, as long as the sink keeps up.
// Pipeline: a result becomes visible at the output once the request that releases it
//   is accepted and has passed line-store read and window shift, sum, and scale
//   by 1/9 into the output queue, in that order.
// Reset (arst_n low): raster counters and owed-output count clear, size returns
//   to 512x512; line stores and window are not cleared and need no sweep.
module box_filter_3x3_core #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [bf3_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [bf3_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	bf3_stream_if.sink                       in_stream,
	bf3_stream_if.source                     out_stream
);
	import bf3_pkg::*;

	localparam int AW   = $clog2(MAX_WIDTH);
	localparam int WMAX = (MAX_WIDTH < CFG_WIDTH_MAX) ? MAX_WIDTH : CFG_WIDTH_MAX;
	localparam int WW   = $clog2(WMAX + 1);
	localparam int PW   = $clog2(WMAX + 2);
	localparam int CW   = (AW + 1 > WW) ? AW + 1 : WW;

	// configuration
	logic [CFG_WIDTH_W-1:0]  image_width_q;
	logic [CFG_HEIGHT_W-1:0] image_height_q;
	logic [WW-1:0]           width_eff;
	logic [CFG_HEIGHT_W-1:0] height_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= IMAGE_WIDTH_RESET;
			image_height_q <= IMAGE_HEIGHT_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_wdata[CFG_WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_wdata[CFG_HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (image_width_q == '0) begin
			width_eff = WW'(1);
		end else if (image_width_q > CFG_WIDTH_W'(WMAX)) begin
			width_eff = WW'(WMAX);
		end else begin
			width_eff = WW'(image_width_q);
		end
		if (image_height_q == '0) begin
			height_eff = CFG_HEIGHT_W'(1);
		end else if (image_height_q > MAX_HEIGHT) begin
			height_eff = MAX_HEIGHT;
		end else begin
			height_eff = image_height_q;
		end
	end

	// raster counters and request decode
	logic [AW-1:0]    in_col_q, out_col_q, in_col_next, out_col_next;
	logic [ROW_W-1:0] in_row_q, out_row_q, in_row_next, out_row_next;
	logic [PW-1:0]    pending_q;
	logic             in_acc, is_flush, flush_ok, emitting, emit0;
	logic             interior0, last0, sel_two0;
	logic             in_col_wrap, out_col_wrap, in_row_wrap, out_row_wrap;

	assign in_acc   = in_stream.valid && in_stream.ready;
	assign is_flush = (in_stream.data.operation == OP_FLUSH);

	always_comb begin
		in_col_wrap  = (CW'(in_col_q) + CW'(1)) >= CW'(width_eff);
		in_row_wrap  = (CFG_HEIGHT_W'(in_row_q) + CFG_HEIGHT_W'(1)) >= height_eff;
		out_col_wrap = (CW'(out_col_q) + CW'(1)) >= CW'(width_eff);
		out_row_wrap = (CFG_HEIGHT_W'(out_row_q) + CFG_HEIGHT_W'(1)) >= height_eff;

		in_col_next  = in_col_wrap ? '0 : in_col_q + AW'(1);
		in_row_next  = in_row_q;
		if (in_col_wrap) begin
			in_row_next = in_row_wrap ? '0 : in_row_q + ROW_W'(1);
		end
		out_col_next = out_col_wrap ? '0 : out_col_q + AW'(1);
		out_row_next = out_row_q;
		if (out_col_wrap) begin
			out_row_next = out_row_wrap ? '0 : out_row_q + ROW_W'(1);
		end

		// flushes only drain at a frame boundary
		flush_ok  = (pending_q != '0) && (in_col_q == '0) && (in_row_q == '0);
		emitting  = pending_q >= (PW'(width_eff) + PW'(1));
		emit0     = is_flush ? flush_ok : emitting;
		sel_two0  = (pending_q - PW'(1)) >= PW'(width_eff);
		interior0 = (out_row_q != '0)
			&& ((CFG_HEIGHT_W'(out_row_q) + CFG_HEIGHT_W'(1)) < height_eff)
			&& (out_col_q != '0)
			&& ((CW'(out_col_q) + CW'(1)) < CW'(width_eff));
		last0     = ((CFG_HEIGHT_W'(out_row_q) + CFG_HEIGHT_W'(1)) == height_eff)
			&& ((CW'(out_col_q) + CW'(1)) == CW'(width_eff));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q  <= '0;
			in_row_q  <= '0;
			out_col_q <= '0;
			out_row_q <= '0;
			pending_q <= '0;
		end else if (in_acc) begin
			if (!is_flush) begin
				in_col_q <= in_col_next;
				in_row_q <= in_row_next;
				if (!emitting) begin
					pending_q <= pending_q + PW'(1);
				end
			end else if (flush_ok) begin
				pending_q <= pending_q - PW'(1);
			end
			if (emit0) begin
				out_col_q <= out_col_next;
				out_row_q <= out_row_next;
			end
		end
	end

	// stage 1: line-store data back, forward last write, shift window
	logic          pix_s1, emit_s1;
	logic          interior_s1, last_s1, use_two_s1;
	pixel_t        px_s1;
	logic [AW-1:0] ic_s1, oc_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1  <= 1'b0;
			emit_s1 <= 1'b0;
		end else begin
			pix_s1  <= in_acc && !is_flush;
			emit_s1 <= in_acc && emit0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			interior_s1 <= !is_flush && interior0;
			last_s1     <= last0;
			use_two_s1  <= !is_flush || sel_two0;
			px_s1       <= in_stream.data.pixel;
			ic_s1       <= in_col_q;
			oc_s1       <= out_col_q;
		end
	end

	pixel_t la_rd_ic, la_rd_oc, l2a_rd_ic, l2a_rd_oc;
	pixel_t la_ic, la_oc, l2a_ic, l2a_oc, copy_s1;
	logic   wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	pixel_t wr_la_q, wr_l2a_q;
	logic   hit_ic, hit_oc;

	bf3_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_line_above (
		.clk     (clk),
		.we      (pix_s1),
		.waddr   (ic_s1),
		.wdata   (px_s1),
		.raddr_a (in_col_q),
		.rdata_a (la_rd_ic),
		.raddr_b (out_col_q),
		.rdata_b (la_rd_oc)
	);

	bf3_ram #(
		.WIDTH (PIXEL_W),
		.DEPTH (MAX_WIDTH)
	) u_line_two_above (
		.clk     (clk),
		.we      (pix_s1),
		.waddr   (ic_s1),
		.wdata   (la_ic),
		.raddr_a (in_col_q),
		.rdata_a (l2a_rd_ic),
		.raddr_b (out_col_q),
		.rdata_b (l2a_rd_oc)
	);

	// the previous request's write lands on the same edge as this read
	always_comb begin
		hit_ic  = wr_valid_q && (wr_addr_q == ic_s1);
		hit_oc  = wr_valid_q && (wr_addr_q == oc_s1);
		la_ic   = hit_ic ? wr_la_q  : la_rd_ic;
		l2a_ic  = hit_ic ? wr_l2a_q : l2a_rd_ic;
		la_oc   = hit_oc ? wr_la_q  : la_rd_oc;
		l2a_oc  = hit_oc ? wr_l2a_q : l2a_rd_oc;
		copy_s1 = use_two_s1 ? l2a_oc : la_oc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (pix_s1) begin
			wr_addr_q <= ic_s1;
			wr_la_q   <= px_s1;
			wr_l2a_q  <= la_ic;
		end
	end

	column_t                new_col;
	column_t                cell_col [WIN_SIZE];
	logic [COL_SUM_W-1:0]   cell_sum [WIN_SIZE];

	always_comb begin
		new_col[0] = l2a_ic;
		new_col[1] = la_ic;
		new_col[2] = px_s1;
	end

	for (genvar i = 0; i < WIN_SIZE; i++) begin : g_cell
		if (i == WIN_SIZE - 1) begin : g_head
			bf3_col_cell u_cell (
				.clk      (clk),
				.shift_en (pix_s1),
				.col_in   (new_col),
				.col_out  (cell_col[i]),
				.col_sum  (cell_sum[i])
			);
		end else begin : g_body
			bf3_col_cell u_cell (
				.clk      (clk),
				.shift_en (pix_s1),
				.col_in   (cell_col[i+1]),
				.col_out  (cell_col[i]),
				.col_sum  (cell_sum[i])
			);
		end
	end

	// stage 2: window sum
	logic                 emit_s2, interior_s2, last_s2;
	pixel_t               copy_s2;
	logic [WIN_SUM_W-1:0] win_sum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s2 <= 1'b0;
		end else begin
			emit_s2 <= emit_s1;
		end
	end

	always_ff @(posedge clk) begin
		interior_s2 <= interior_s1;
		last_s2     <= last_s1;
		copy_s2     <= copy_s1;
	end

	assign win_sum = WIN_SUM_W'(cell_sum[0]) + WIN_SUM_W'(cell_sum[1])
		+ WIN_SUM_W'(cell_sum[2]);

	// stage 3: divide by nine, pick mean or border copy
	logic                 emit_s3, interior_s3, last_s3;
	pixel_t               copy_s3;
	logic [WIN_SUM_W-1:0] sum_s3;
	logic [PROD_W-1:0]    prod;
	bf3_out_t             result;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_s3 <= 1'b0;
		end else begin
			emit_s3 <= emit_s2;
		end
	end

	always_ff @(posedge clk) begin
		interior_s3 <= interior_s2;
		last_s3     <= last_s2;
		copy_s3     <= copy_s2;
		sum_s3      <= win_sum;
	end

	always_comb begin
		prod                  = PROD_W'(sum_s3) * PROD_W'(DIV9_RECIP);
		result.filtered_pixel = interior_s3 ? prod[DIV9_SHIFT +: PIXEL_W] : copy_s3;
		result.last_of_frame  = last_s3;
	end

	// output queue; a slot is reserved when a result-producing request is taken
	logic                  pop, fifo_valid;
	bf3_out_t              fifo_head;
	logic [FIFO_CNT_W-1:0] occ_q;
	logic                  reserve;

	assign pop     = fifo_valid && out_stream.ready;
	assign reserve = in_acc && emit0;

	bf3_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (emit_s3),
		.push_data (result),
		.pop       (pop),
		.out_valid (fifo_valid),
		.out_data  (fifo_head)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			case ({reserve, pop})
				2'b10:   occ_q <= occ_q + FIFO_CNT_W'(1);
				2'b01:   occ_q <= occ_q - FIFO_CNT_W'(1);
				default: occ_q <= occ_q;
			endcase
		end
	end

	assign in_stream.ready  = (occ_q < FIFO_CNT_W'(OUT_FIFO_DEPTH));
	assign out_stream.valid = fifo_valid;
	assign out_stream.data  = fifo_head;
endmodule

>>> rtl/bf3_checker.sv
module bf3_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [bf3_pkg::PIXEL_W-1:0] out_pixel,
	input logic                  out_last
);
	import bf3_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("output request dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(out_pixel) && $stable(out_last))
		else $error("output payload changed while stalled");

	// the pipeline is fixed length, so an empty output only comes alive for
	// a request that fed it and was accepted earlier
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 4))
		else $error("output appeared without a matching request");

	// input back-pressure only comes from a stalled, well-filled output queue
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(in_ready) |-> $past(out_valid && !out_ready))
		else $error("input stalled while output was draining");
endmodule

bind box_filter_3x3_core bf3_checker u_bf3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_stream.valid),
	.in_ready  (in_stream.ready),
	.out_valid (out_stream.valid),
	.out_ready (out_stream.ready),
	.out_pixel (out_stream.data.filtered_pixel),
	.out_last  (out_stream.data.last_of_frame)
);
